// ===== src/vpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_pkg
// Shared types and constants for the video processor host port: port codes,
// operation codes, the classified item that travels from front to back.
// ----------------------------------------------------------------------------
package vpc_pkg;

  // video memory
  localparam int VRAM_BYTES_DEF = 131072;
  localparam int ADDR_W         = 17;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // decoded ports
  localparam logic [7:0] PORT_VRAM    = 8'h98;
  localparam logic [7:0] PORT_CTRL    = 8'h99;
  localparam logic [7:0] PORT_PALETTE = 8'h9A;
  localparam logic [7:0] PORT_INDIR   = 8'h9B;

  // open-bus read value
  localparam logic [7:0] OPEN_BUS = 8'hFF;

  // register indexes that the port logic looks at
  localparam logic [5:0] REG_MODE1   = 6'd1;
  localparam logic [5:0] REG_ADDR_HI = 6'd14;
  localparam logic [5:0] REG_STATSEL = 6'd15;
  localparam logic [5:0] REG_PALPTR  = 6'd16;
  localparam logic [5:0] REG_INDPTR  = 6'd17;

  // second control byte codes in bits 7..6
  localparam logic [1:0] CTRL_REG_WRITE = 2'b10;
  localparam logic [1:0] CTRL_ADDR_WR   = 2'b01;

  // mode register bits
  localparam int M1_IRQ_EN  = 5;
  localparam int M1_DISP_EN = 6;

  // operation codes on the input channel
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FRAME = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // classified item kinds
  typedef enum logic [3:0] {
    K_NOP,
    K_RD_VRAM,
    K_RD_STAT,
    K_RD_OPEN,
    K_WR_VRAM,
    K_WR_CTRL,
    K_WR_PAL,
    K_WR_IND,
    K_FRAME
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

endpackage : vpc_pkg
`default_nettype wire

// ===== src/vpc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_ram
// Generic single-port RAM with a registered read; read data holds until the
// next read.
// ----------------------------------------------------------------------------
module vpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule : vpc_ram
`default_nettype wire

// ===== src/vpc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_front
// Accepts host items and classifies them by operation and port into the
// kinds the back end carries out.
// ----------------------------------------------------------------------------
module vpc_front (
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_operation,
  input  wire logic [7:0]    in_port,
  input  wire logic [7:0]    in_write_data,
  input  wire logic          busy,
  input  wire logic          q_full,
  output logic               in_stall,
  output logic               push,
  output vpc_pkg::item_t     item
);
  import vpc_pkg::*;

  // hold off while the back end clears memory or the queue is full
  assign in_stall = busy | q_full;
  assign push     = in_valid & ~in_stall;

  // classify
  always_comb begin
    item.data = in_write_data;
    item.kind = K_NOP;
    unique case (op_t'(in_operation))
      OP_READ: begin
        priority if (in_port == PORT_VRAM) item.kind = K_RD_VRAM;
        else if (in_port == PORT_CTRL)     item.kind = K_RD_STAT;
        else                               item.kind = K_RD_OPEN;
      end
      OP_WRITE: begin
        priority if (in_port == PORT_VRAM) item.kind = K_WR_VRAM;
        else if (in_port == PORT_CTRL)     item.kind = K_WR_CTRL;
        else if (in_port == PORT_PALETTE)  item.kind = K_WR_PAL;
        else if (in_port == PORT_INDIR)    item.kind = K_WR_IND;
        else                               item.kind = K_NOP;
      end
      OP_FRAME: item.kind = K_FRAME;
      OP_NONE:  item.kind = K_NOP;
    endcase
  end

endmodule : vpc_front
`default_nettype wire

// ===== src/vpc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_queue
// Short item queue between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module vpc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire vpc_pkg::item_t push_item,
  input  wire logic          pop,
  output logic               full,
  output logic               q_valid,
  output vpc_pkg::item_t     head
);
  import vpc_pkg::*;

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule : vpc_queue
`default_nettype wire

// ===== src/vpc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_back
// Carries out classified items: VRAM access with read-ahead, control and
// palette sequences, indirect register writes, status and interrupt. Also
// runs the VRAM clearing pass after reset and holds the result register.
// ----------------------------------------------------------------------------
module vpc_back #(
  parameter int VRAM_BYTES = vpc_pkg::VRAM_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire vpc_pkg::item_t                head,
  output logic                               pop,
  output logic                               busy,
  // vram port
  output logic                               ram_we,
  output logic                               ram_re,
  output logic [$clog2(VRAM_BYTES)-1:0]      ram_addr,
  output logic [7:0]                         ram_wdata,
  input  wire logic [7:0]                    ram_rdata,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_read_data,
  output logic                               out_irq_level,
  output logic                               out_palette_written,
  output logic [3:0]                         out_palette_slot,
  output logic [8:0]                         out_palette_color
);
  import vpc_pkg::*;

  localparam int AW = $clog2(VRAM_BYTES);

  // clearing pass
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  // port state
  logic [7:0]        r1_r, r1_nxt;
  logic [7:0]        r14_r, r14_nxt;
  logic [7:0]        r15_r, r15_nxt;
  logic [7:0]        r16_r, r16_nxt;
  logic [7:0]        r17_r, r17_nxt;
  logic              frame_f_r, frame_f_nxt;
  logic              irq_r, irq_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        ctrl_latch_r, ctrl_latch_nxt;
  logic              ctrl_second_r, ctrl_second_nxt;
  logic [7:0]        ra_r, ra_nxt;
  logic              ra_ram_r, ra_ram_nxt;
  logic [7:0]        pal_first_r, pal_first_nxt;
  logic              pal_phase_r, pal_phase_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] rd_data_r, rd_data_nxt;
  logic       pal_wr_r, pal_wr_nxt;
  logic [3:0] pal_slot_r, pal_slot_nxt;
  logic [8:0] pal_color_r, pal_color_nxt;

  // execute scratch
  logic              fire;
  logic [7:0]        ra_eff;
  logic              reg_we;
  logic [5:0]        reg_idx;
  logic [7:0]        reg_val;
  logic              b_we, b_re;
  logic [AW-1:0]     b_addr;
  logic [ADDR_W-1:0] ctrl_addr;
  logic [3:0]        pal_slot;
  logic [5:0]        ind_reg;

  assign busy = clearing_r;
  assign fire = q_valid & ~clearing_r & (~out_valid_r | ~out_stall);
  assign pop  = fire;

  // read-ahead byte is in the ram output register after a prefetch
  assign ra_eff    = ra_ram_r ? ram_rdata : ra_r;
  assign ctrl_addr = {r14_r[2:0], head.data[5:0], ctrl_latch_r};
  assign pal_slot  = r16_r[3:0];
  assign ind_reg   = r17_r[5:0];

  // item execution
  always_comb begin
    r1_nxt          = r1_r;
    r14_nxt         = r14_r;
    r15_nxt         = r15_r;
    r16_nxt         = r16_r;
    r17_nxt         = r17_r;
    frame_f_nxt     = frame_f_r;
    irq_nxt         = irq_r;
    addr_nxt        = addr_r;
    ctrl_latch_nxt  = ctrl_latch_r;
    ctrl_second_nxt = ctrl_second_r;
    ra_nxt          = ra_r;
    ra_ram_nxt      = ra_ram_r;
    pal_first_nxt   = pal_first_r;
    pal_phase_nxt   = pal_phase_r;
    rd_data_nxt     = '0;
    pal_wr_nxt      = 1'b0;
    pal_slot_nxt    = '0;
    pal_color_nxt   = '0;
    reg_we          = 1'b0;
    reg_idx         = '0;
    reg_val         = '0;
    b_we            = 1'b0;
    b_re            = 1'b0;
    b_addr          = addr_r[AW-1:0];

    unique case (head.kind)
      K_RD_VRAM: begin
        rd_data_nxt     = ra_eff;
        b_re            = 1'b1;
        ra_ram_nxt      = 1'b1;
        addr_nxt        = addr_r + 1'b1;
        ctrl_second_nxt = 1'b0;
      end
      K_RD_STAT: begin
        if (r15_r[3:0] == 4'd0) begin
          rd_data_nxt = {frame_f_r, 7'd0};
          frame_f_nxt = 1'b0;
          irq_nxt     = 1'b0;
        end
        ctrl_second_nxt = 1'b0;
      end
      K_RD_OPEN: rd_data_nxt = OPEN_BUS;
      K_WR_VRAM: begin
        b_we            = 1'b1;
        ra_nxt          = head.data;
        ra_ram_nxt      = 1'b0;
        addr_nxt        = addr_r + 1'b1;
        ctrl_second_nxt = 1'b0;
      end
      K_WR_CTRL: begin
        if (!ctrl_second_r) begin
          ctrl_latch_nxt  = head.data;
          ctrl_second_nxt = 1'b1;
        end else begin
          ctrl_second_nxt = 1'b0;
          if (head.data[7:6] == CTRL_REG_WRITE) begin
            reg_we  = 1'b1;
            reg_idx = head.data[5:0];
            reg_val = ctrl_latch_r;
          end else if (head.data[7:6] == CTRL_ADDR_WR) begin
            addr_nxt = ctrl_addr;
          end else begin
            // address set with prefetch
            b_re       = 1'b1;
            b_addr     = ctrl_addr[AW-1:0];
            ra_ram_nxt = 1'b1;
            addr_nxt   = ctrl_addr + 1'b1;
          end
        end
      end
      K_WR_PAL: begin
        if (!pal_phase_r) begin
          pal_first_nxt = head.data;
          pal_phase_nxt = 1'b1;
        end else begin
          pal_phase_nxt = 1'b0;
          pal_wr_nxt    = 1'b1;
          pal_slot_nxt  = pal_slot;
          pal_color_nxt = {pal_first_r[6:4], head.data[2:0], pal_first_r[2:0]};
          r16_nxt       = {r16_r[7:4], pal_slot + 1'b1};
        end
      end
      K_WR_IND: begin
        reg_we  = (ind_reg != REG_INDPTR);
        reg_idx = ind_reg;
        reg_val = head.data;
        if (!r17_r[7]) begin
          r17_nxt = {r17_r[7:6], ind_reg + 1'b1};
        end
      end
      K_FRAME: begin
        if (r1_r[M1_DISP_EN]) begin
          frame_f_nxt = 1'b1;
          if (r1_r[M1_IRQ_EN]) irq_nxt = 1'b1;
        end
      end
      K_NOP: ;
      default: ;
    endcase

    // register file write
    if (reg_we) begin
      unique case (reg_idx)
        REG_MODE1: begin
          r1_nxt = reg_val;
          if (reg_val[M1_IRQ_EN] && frame_f_r) irq_nxt = 1'b1;
        end
        REG_ADDR_HI: r14_nxt = reg_val;
        REG_STATSEL: r15_nxt = reg_val;
        REG_PALPTR:  r16_nxt = reg_val;
        REG_INDPTR:  r17_nxt = reg_val;
        default: ;
      endcase
    end
  end

  // vram port: clearing pass or item access
  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_re    = 1'b0;
      ram_addr  = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = fire & b_we;
      ram_re    = fire & b_re;
      ram_addr  = b_addr;
      ram_wdata = head.data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r    <= 1'b1;
      clr_addr_r    <= '0;
      r1_r          <= '0;
      r14_r         <= '0;
      r15_r         <= '0;
      r16_r         <= '0;
      r17_r         <= '0;
      frame_f_r     <= 1'b0;
      irq_r         <= 1'b0;
      addr_r        <= '0;
      ctrl_latch_r  <= '0;
      ctrl_second_r <= 1'b0;
      ra_r          <= '0;
      ra_ram_r      <= 1'b0;
      pal_first_r   <= '0;
      pal_phase_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (clearing_r) begin
        if (clr_addr_r == AW'(VRAM_BYTES - 1)) clearing_r <= 1'b0;
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (fire) begin
        r1_r          <= r1_nxt;
        r14_r         <= r14_nxt;
        r15_r         <= r15_nxt;
        r16_r         <= r16_nxt;
        r17_r         <= r17_nxt;
        frame_f_r     <= frame_f_nxt;
        irq_r         <= irq_nxt;
        addr_r        <= addr_nxt;
        ctrl_latch_r  <= ctrl_latch_nxt;
        ctrl_second_r <= ctrl_second_nxt;
        ra_r          <= ra_nxt;
        ra_ram_r      <= ra_ram_nxt;
        pal_first_r   <= pal_first_nxt;
        pal_phase_r   <= pal_phase_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      rd_data_r   <= rd_data_nxt;
      pal_wr_r    <= pal_wr_nxt;
      pal_slot_r  <= pal_slot_nxt;
      pal_color_r <= pal_color_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = rd_data_r;
  assign out_irq_level       = irq_r;
  assign out_palette_written = pal_wr_r;
  assign out_palette_slot    = pal_slot_r;
  assign out_palette_color   = pal_color_r;

endmodule : vpc_back
`default_nettype wire

// ===== src/video_processor_cpu_port_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// video_processor_cpu_port_core
// Host bus side of a video display processor: VRAM, register, palette and
// status access through ports 0x98..0x9B, plus frame-end flag and interrupt.
// ----------------------------------------------------------------------------
// One result item per input item. After reset the block sweeps VRAM to zero,
// one byte per cycle, with in_stall high until every byte is cleared. After
// that it sustains one item per cycle while nothing stalls: the front
// classifies and pushes into a two-entry queue, the back executes one item
// per cycle while out_stall does not hold a waiting result, against the single
// VRAM port (registered read; the read-ahead byte is taken straight from the
// RAM output register) and loads the result register. An accepted item is
// written into the queue first; its result is offered once the back executes it.
module video_processor_cpu_port_core #(
  parameter int VRAM_BYTES = vpc_pkg::VRAM_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_port,
  input  wire logic [7:0] in_write_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data,
  output logic            out_irq_level,
  output logic            out_palette_written,
  output logic [3:0]      out_palette_slot,
  output logic [8:0]      out_palette_color
);
  import vpc_pkg::*;

  localparam int AW = $clog2(VRAM_BYTES);

  logic          busy;
  logic          q_full;
  logic          push;
  item_t         push_item;
  logic          pop;
  logic          q_valid;
  item_t         head;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // front: accept and classify
  vpc_front u_front (
    .in_valid      (in_valid),
    .in_operation  (in_operation),
    .in_port       (in_port),
    .in_write_data (in_write_data),
    .busy          (busy),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .push          (push),
    .item          (push_item)
  );

  // queue between front and back
  vpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .head      (head)
  );

  // back: execute
  vpc_back #(
    .VRAM_BYTES (VRAM_BYTES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .head                (head),
    .pop                 (pop),
    .busy                (busy),
    .ram_we              (ram_we),
    .ram_re              (ram_re),
    .ram_addr            (ram_addr),
    .ram_wdata           (ram_wdata),
    .ram_rdata           (ram_rdata),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_irq_level       (out_irq_level),
    .out_palette_written (out_palette_written),
    .out_palette_slot    (out_palette_slot),
    .out_palette_color   (out_palette_color)
  );

  // video memory
  vpc_ram #(
    .WIDTH (8),
    .DEPTH (VRAM_BYTES)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule : video_processor_cpu_port_core
`default_nettype wire

// ===== tb/tb_video_processor_cpu_port_core.sv =====
// ----------------------------------------------------------------------------
// tb_video_processor_cpu_port_core
// Self-checking bench for the video processor host port. A scoreboard keeps
// its own copy of VRAM, registers, status and latches, predicts the result of
// every accepted item and checks results in order. Directed items cover the
// corner cases, then about 1600 random items run in four idle/stall phases
// with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_video_processor_cpu_port_core;
  import vpc_pkg::*;

  localparam int          ITEM_TARGET    = 1600;
  localparam int          PHASE_ITEMS    = 400;
  localparam int          HOLD_CYCLES    = 200;
  localparam int          DRAIN_CYCLES   = 16;
  localparam int          WATCHDOG_LIMIT = 400000;
  localparam logic [7:0]  STAT_KEEP_MASK = 8'h1F;
  localparam int          STAT_FRAME_BIT = 7;
  localparam logic [1:0]  CTRL_ADDR_RD   = 2'b00;
  localparam logic [1:0]  CTRL_ADDR_ALT  = 2'b11;

  // expected view of the port, one item in, one result out
  class port_scoreboard;
    typedef struct {
      logic [7:0] read_data;
      logic       irq_level;
      logic       palette_written;
      logic [3:0] palette_slot;
      logic [8:0] palette_color;
    } port_result_t;

    bit [7:0]        vram [VRAM_BYTES_DEF];
    bit [7:0]        regs [64];
    bit [7:0]        status0;
    bit              irq;
    bit [ADDR_W-1:0] vram_addr;
    bit [7:0]        ctrl_latch;
    bit              ctrl_second;
    bit [7:0]        read_ahead;
    bit [7:0]        pal_first;
    bit              pal_phase;
    port_result_t    pending_results[$];
    int              errors;

    function new();
      foreach (vram[i]) vram[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      status0     = '0;
      irq         = 1'b0;
      vram_addr   = '0;
      ctrl_latch  = '0;
      ctrl_second = 1'b0;
      read_ahead  = '0;
      pal_first   = '0;
      pal_phase   = 1'b0;
      errors      = 0;
    endfunction

    // register write, mode register may raise the interrupt
    function void write_reg(bit [5:0] idx, bit [7:0] val);
      regs[idx] = val;
      if (idx == REG_MODE1 && val[M1_IRQ_EN] && status0[STAT_FRAME_BIT])
        irq = 1'b1;
    endfunction

    // predict the result of one accepted item
    function void note_access(op_t op, bit [7:0] port, bit [7:0] data);
      port_result_t res;
      bit [5:0]     ptr;
      bit [3:0]     slot;
      bit [8:0]     color;
      res = '{read_data: 8'h00, irq_level: 1'b0, palette_written: 1'b0,
              palette_slot: 4'h0, palette_color: 9'h000};
      case (op)
        OP_READ: begin
          if (port == PORT_VRAM) begin
            res.read_data = read_ahead;
            read_ahead    = vram[vram_addr];
            vram_addr     = vram_addr + 1'b1;
            ctrl_second   = 1'b0;
          end else if (port == PORT_CTRL) begin
            if (regs[REG_STATSEL][3:0] == 4'h0) begin
              res.read_data = status0;
              status0       = status0 & STAT_KEEP_MASK;
              irq           = 1'b0;
            end
            ctrl_second = 1'b0;
          end else begin
            res.read_data = OPEN_BUS;
          end
        end
        OP_WRITE: begin
          if (port == PORT_VRAM) begin
            vram[vram_addr] = data;
            read_ahead      = data;
            vram_addr       = vram_addr + 1'b1;
            ctrl_second     = 1'b0;
          end else if (port == PORT_CTRL) begin
            if (!ctrl_second) begin
              ctrl_latch  = data;
              ctrl_second = 1'b1;
            end else begin
              ctrl_second = 1'b0;
              if (data[7:6] == CTRL_REG_WRITE) begin
                write_reg(data[5:0], ctrl_latch);
              end else begin
                vram_addr = {regs[REG_ADDR_HI][2:0], data[5:0], ctrl_latch};
                // every pattern but write setup prefetches
                if (data[7:6] != CTRL_ADDR_WR) begin
                  read_ahead = vram[vram_addr];
                  vram_addr  = vram_addr + 1'b1;
                end
              end
            end
          end else if (port == PORT_PALETTE) begin
            slot = regs[REG_PALPTR][3:0];
            if (!pal_phase) begin
              pal_first = data;
              pal_phase = 1'b1;
            end else begin
              color                   = {pal_first[6:4], data[2:0], pal_first[2:0]};
              pal_phase               = 1'b0;
              regs[REG_PALPTR][3:0]   = slot + 1'b1;
              res.palette_written     = 1'b1;
              res.palette_slot        = slot;
              res.palette_color       = color;
            end
          end else if (port == PORT_INDIR) begin
            ptr = regs[REG_INDPTR][5:0];
            // the pointer register cannot write itself
            if (ptr != REG_INDPTR)
              write_reg(ptr, data);
            if (!regs[REG_INDPTR][7])
              regs[REG_INDPTR][5:0] = ptr + 1'b1;
          end
        end
        OP_FRAME: begin
          if (regs[REG_MODE1][M1_DISP_EN]) begin
            status0[STAT_FRAME_BIT] = 1'b1;
            if (regs[REG_MODE1][M1_IRQ_EN])
              irq = 1'b1;
          end
        end
        default: ;
      endcase
      res.irq_level = irq;
      pending_results.push_back(res);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(logic [7:0] rd, logic irq_lvl, logic pw,
                               logic [3:0] slot, logic [8:0] color);
      port_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: read_data %0h", rd);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (rd !== exp_res.read_data) begin
        $error("read_data: expected %0h, got %0h", exp_res.read_data, rd);
        errors++;
      end
      if (irq_lvl !== exp_res.irq_level) begin
        $error("irq_level: expected %0h, got %0h", exp_res.irq_level, irq_lvl);
        errors++;
      end
      if (pw !== exp_res.palette_written) begin
        $error("palette_written: expected %0h, got %0h", exp_res.palette_written, pw);
        errors++;
      end
      if (slot !== exp_res.palette_slot) begin
        $error("palette_slot: expected %0h, got %0h", exp_res.palette_slot, slot);
        errors++;
      end
      if (color !== exp_res.palette_color) begin
        $error("palette_color: expected %0h, got %0h", exp_res.palette_color, color);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_operation;
  logic [7:0] in_port;
  logic [7:0] in_write_data;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_read_data;
  logic       out_irq_level;
  logic       out_palette_written;
  logic [3:0] out_palette_slot;
  logic [8:0] out_palette_color;

  port_scoreboard sb;
  int             items_sent;
  int             send_idle_pct;
  int             recv_stall_pct;
  bit             hold_request;
  bit             hold_done;
  int             quiet_cycles;
  logic [7:0]     recent_latch;
  logic [5:0]     recent_hi;

  video_processor_cpu_port_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_port             (in_port),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_irq_level       (out_irq_level),
    .out_palette_written (out_palette_written),
    .out_palette_slot    (out_palette_slot),
    .out_palette_color   (out_palette_color)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // offer one item, called at a falling edge, returns at a falling edge
  task automatic offer_item(op_t op, logic [7:0] port, logic [7:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_port       <= port;
    in_write_data <= data;
    do @(posedge clk); while (in_stall);
    sb.note_access(op, port, data);
    items_sent++;
    @(negedge clk);
  endtask

  // two-byte register write through the control port
  task automatic set_reg(logic [5:0] idx, logic [7:0] val);
    offer_item(OP_WRITE, PORT_CTRL, val);
    offer_item(OP_WRITE, PORT_CTRL, {CTRL_REG_WRITE, idx});
  endtask

  // two-byte address set through the control port
  task automatic set_vram_address(logic [1:0] code, logic [5:0] hi, logic [7:0] lo);
    offer_item(OP_WRITE, PORT_CTRL, lo);
    offer_item(OP_WRITE, PORT_CTRL, {code, hi});
  endtask

  // one random well-formed sequence, or noise
  task automatic random_sequence();
    int         pick;
    int         n;
    logic [5:0] idx;
    logic [7:0] val;
    logic [1:0] code;
    pick = $urandom_range(99);
    if (pick < 20) begin
      // vram burst
      n = $urandom_range(6, 1);
      repeat (n)
        offer_item($urandom_range(1) ? OP_WRITE : OP_READ, PORT_VRAM, 8'($urandom));
    end else if (pick < 35) begin
      // address set, often back to a recent spot to read written data
      if ($urandom_range(2) == 0)
        set_reg(REG_ADDR_HI, $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom));
      case ($urandom_range(2))
        0:       code = CTRL_ADDR_RD;
        1:       code = CTRL_ADDR_WR;
        default: code = CTRL_ADDR_ALT;
      endcase
      if ($urandom_range(1)) begin
        recent_latch = 8'($urandom);
        recent_hi    = 6'($urandom);
      end
      set_vram_address(code, recent_hi, recent_latch);
    end else if (pick < 50) begin
      case ($urandom_range(5))
        0:       idx = REG_MODE1;
        1:       idx = REG_ADDR_HI;
        2:       idx = REG_STATSEL;
        3:       idx = REG_PALPTR;
        4:       idx = REG_INDPTR;
        default: idx = 6'($urandom);
      endcase
      val = 8'($urandom);
      // keep the status selector mostly on the frame status
      if (idx == REG_STATSEL && $urandom_range(3) != 0)
        val = 8'h00;
      set_reg(idx, val);
    end else if (pick < 60) begin
      offer_item(OP_WRITE, PORT_PALETTE, 8'($urandom));
      offer_item(OP_WRITE, PORT_PALETTE, 8'($urandom));
    end else if (pick < 70) begin
      // indirect writes, pointer sometimes at itself
      val = 8'($urandom);
      if ($urandom_range(3) == 0)
        val[5:0] = REG_INDPTR;
      set_reg(REG_INDPTR, val);
      n = $urandom_range(4, 1);
      repeat (n)
        offer_item(OP_WRITE, PORT_INDIR, 8'($urandom));
    end else if (pick < 80) begin
      offer_item(OP_READ, PORT_CTRL, 8'($urandom));
    end else if (pick < 90) begin
      offer_item(OP_FRAME, 8'($urandom), 8'($urandom));
    end else begin
      offer_item(op_t'($urandom_range(3)),
                 $urandom_range(1) ? 8'($urandom_range(8'h9B, 8'h98)) : 8'($urandom),
                 8'($urandom));
    end
  endtask

  // receiver: random stall, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_read_data, out_irq_level, out_palette_written,
                      out_palette_slot, out_palette_color);
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // main sequence
  initial begin
    sb             = new();
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    hold_done      = 1'b0;
    quiet_cycles   = 0;
    recent_latch   = 8'h00;
    recent_hi      = 6'h00;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_READ;
    in_port       <= 8'h00;
    in_write_data <= 8'h00;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corner cases
    offer_item(OP_READ, PORT_VRAM, 8'h00);
    offer_item(OP_WRITE, PORT_VRAM, 8'hFF);
    offer_item(OP_WRITE, PORT_VRAM, 8'h00);
    set_vram_address(CTRL_ADDR_RD, 6'h00, 8'h00);
    offer_item(OP_READ, PORT_VRAM, 8'h55);
    set_vram_address(CTRL_ADDR_WR, 6'h3F, 8'hFF);
    offer_item(OP_FRAME, PORT_VRAM, 8'h00);       // display off: no flag
    set_reg(REG_MODE1, 8'h40);
    offer_item(OP_FRAME, 8'hFF, 8'hFF);           // flag set, no interrupt
    set_reg(REG_MODE1, 8'h60);                    // enable raises the line
    offer_item(OP_READ, PORT_CTRL, 8'h00);        // frame status read clears
    set_reg(REG_STATSEL, 8'h0F);
    offer_item(OP_READ, PORT_CTRL, 8'h00);        // other status reads zero
    offer_item(OP_WRITE, PORT_PALETTE, 8'hFF);
    offer_item(OP_WRITE, PORT_PALETTE, 8'hFF);
    set_reg(REG_INDPTR, {2'b00, REG_INDPTR});
    offer_item(OP_WRITE, PORT_INDIR, 8'hAA);      // suppressed, pointer moves
    set_reg(REG_INDPTR, {2'b10, REG_MODE1});
    offer_item(OP_WRITE, PORT_INDIR, 8'h00);      // pointer held
    offer_item(OP_WRITE, PORT_INDIR, 8'h60);
    offer_item(OP_READ, 8'h00, 8'h00);            // undecoded read
    offer_item(OP_WRITE, 8'hFF, 8'hFF);           // undecoded write
    offer_item(OP_NONE, PORT_VRAM, 8'hFF);

    // random part in idle/stall phases
    while (items_sent < ITEM_TARGET) begin
      case (items_sent / PHASE_ITEMS)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          if (!hold_done && items_sent >= PHASE_ITEMS / 2) begin
            hold_done    = 1'b1;
            hold_request = 1'b1;
          end
        end
        1: begin
          send_idle_pct  = 64;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 64;
        end
        default: begin
          send_idle_pct  = 31;
          recv_stall_pct = 31;
        end
      endcase
      random_sequence();
    end
    in_valid <= 1'b0;

    // drain
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
src/vpc_pkg.sv
src/vpc_ram.sv
src/vpc_front.sv
src/vpc_queue.sv
src/vpc_back.sv
src/video_processor_cpu_port_core.sv
tb/tb_video_processor_cpu_port_core.sv
